>>> rtl/core/hkl_pkg.sv
// ----------------------------------------------------------------------------
// hkl_pkg: shared definitions of the hashed key list unit
// Field widths, operation and status codes, register indexes, reset values
// and the request and response types of the modular arithmetic unit.
// ----------------------------------------------------------------------------
package hkl_pkg;

    localparam int HASH_W      = 23;
    localparam int KEY_W       = 16;
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int STEP_CNT_W  = $clog2(HASH_W);

    localparam int DEPTH_DEFAULT = 64;

    localparam logic [HASH_W-1:0] BASE_RESET    = HASH_W'(101);
    localparam logic [HASH_W-1:0] MODULUS_RESET = HASH_W'(6562307);

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_COMPARE = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_COMPARED  = 3'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd1;

    // One pass of the modular unit computes (mult * a + c) mod modulus.
    // Both a and c must already be below the modulus.
    typedef struct packed {
        logic              start;
        logic [HASH_W-1:0] mult;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] c;
    } mm_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] result;
    } mm_rsp_t;

endpackage

>>> rtl/core/hkl_in_if.sv
// ----------------------------------------------------------------------------
// hkl_in_if: operation request channel
// Valid and ready handshake carrying one list operation.
// ----------------------------------------------------------------------------
interface hkl_in_if;
    logic                          valid;
    logic                          ready;
    logic [hkl_pkg::FUNC_W-1:0]    func;
    logic [hkl_pkg::KEY_W-1:0]     key_value;
    logic [hkl_pkg::HASH_W-1:0]    other_hash;

    modport source (output valid, output func, output key_value, output other_hash,
                    input ready);
    modport sink   (input valid, input func, input key_value, input other_hash,
                    output ready);
endinterface

>>> rtl/core/hkl_out_if.sv
// ----------------------------------------------------------------------------
// hkl_out_if: result channel
// Valid and ready handshake carrying the outcome of one operation.
// ----------------------------------------------------------------------------
interface hkl_out_if;
    logic                            valid;
    logic                            ready;
    logic [hkl_pkg::STATUS_W-1:0]    status;
    logic                            hashes_equal;
    logic [hkl_pkg::HASH_W-1:0]      hash_now;
    logic [hkl_pkg::COUNT_OUT_W-1:0] key_count;

    modport source (output valid, output status, output hashes_equal, output hash_now,
                    output key_count, input ready);
    modport sink   (input valid, input status, input hashes_equal, input hash_now,
                    input key_count, output ready);
endinterface

>>> rtl/core/hkl_cfg_if.sv
// ----------------------------------------------------------------------------
// hkl_cfg_if: configuration write channel
// Valid and ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface hkl_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [hkl_pkg::CFG_IDX_W-1:0] index;
    logic [hkl_pkg::HASH_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/hkl_modmul.sv
// ----------------------------------------------------------------------------
// hkl_modmul: bit-serial modular multiply-add
// Computes (mult * a + c) mod m one multiplier bit per cycle, MSB first,
// followed by a final step that adds c. A modulus below two yields zero.
// ----------------------------------------------------------------------------
module hkl_modmul
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [hkl_pkg::HASH_W-1:0] modulus,
    input  hkl_pkg::mm_req_t         req,
    output hkl_pkg::mm_rsp_t         rsp
);

    localparam int W = hkl_pkg::HASH_W;

    typedef enum logic [1:0] {
        U_IDLE,
        U_STEP,
        U_FIN
    } ustate_t;

    ustate_t                          state_reg, state_next;
    logic [W-1:0]                     acc_reg, acc_next;
    logic [W-1:0]                     mult_reg, mult_next;
    logic [W-1:0]                     a_reg, a_next;
    logic [W-1:0]                     c_reg, c_next;
    logic [hkl_pkg::STEP_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                             done_reg, done_next;
    logic [W-1:0]                     result_reg, result_next;

    logic [W:0] mod_ext;
    logic [W:0] dbl;
    logic [W:0] dbl_red;
    logic [W:0] add_sum;
    logic [W:0] add_red;
    logic [W:0] fin_sum;
    logic [W:0] fin_red;
    logic       mod_small;

    assign mod_ext   = {1'b0, modulus};
    assign mod_small = (modulus[W-1:1] == '0);

    // Doubling step, then the conditional add of a; each stays below the modulus.
    assign dbl     = {acc_reg, 1'b0};
    assign dbl_red = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
    assign add_sum = {1'b0, dbl_red[W-1:0]} + {1'b0, a_reg};
    assign add_red = (add_sum >= mod_ext) ? (add_sum - mod_ext) : add_sum;
    assign fin_sum = {1'b0, acc_reg} + {1'b0, c_reg};
    assign fin_red = (fin_sum >= mod_ext) ? (fin_sum - mod_ext) : fin_sum;

    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        mult_next   = mult_reg;
        a_next      = a_reg;
        c_next      = c_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    acc_next   = '0;
                    mult_next  = req.mult;
                    a_next     = req.a;
                    c_next     = req.c;
                    cnt_next   = hkl_pkg::STEP_CNT_W'(W - 1);
                    state_next = U_STEP;
                end
            end
            U_STEP:
            begin
                acc_next  = mult_reg[W-1] ? add_red[W-1:0] : dbl_red[W-1:0];
                mult_next = {mult_reg[W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = U_FIN;
                end
            end
            U_FIN:
            begin
                result_next = mod_small ? '0 : fin_red[W-1:0];
                done_next   = 1'b1;
                state_next  = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            acc_reg    <= '0;
            mult_reg   <= '0;
            a_reg      <= '0;
            c_reg      <= '0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
            acc_reg    <= acc_next;
            mult_reg   <= mult_next;
            a_reg      <= a_next;
            c_reg      <= c_next;
            result_reg <= result_next;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

>>> rtl/core/hkl_key_mem.sv
// ----------------------------------------------------------------------------
// hkl_key_mem: key storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hkl_key_mem
#(
    parameter int DEPTH = hkl_pkg::DEPTH_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [hkl_pkg::KEY_W-1:0]     wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [hkl_pkg::KEY_W-1:0]     rd_data
);

    logic [hkl_pkg::KEY_W-1:0] mem [DEPTH];
    logic [hkl_pkg::KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/hashed_key_list_unit.sv
// ----------------------------------------------------------------------------
// hashed_key_list_unit: ordered key list with a polynomial rolling hash
// Keeps up to DEPTH keys and the hash sum(key[j] * base^j) mod modulus.
// ----------------------------------------------------------------------------
// Usage. A request on in_ch carries an operation (insert, search, delete or
// compare hash), a key and another hash. Exactly one result leaves on out_ch
// for each request: a status, the compare flag, the hash and the key count
// after the operation. cfg_ch writes the hash base (index 0) and modulus
// (index 1); it is always ready and must only be used while the unit is idle.
// One request is worked on at a time; in_ch is ready only when the sequencer
// is idle. All modular arithmetic runs through one bit-serial multiply-add
// unit. Compare and an insert into a full list go straight to the output
// state. Insert takes five passes. Search reads the stored keys one at a
// time, oldest first. Delete scans from the newest key, shifts the newer
// keys down and recomputes the hash with two passes per remaining key.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is already accepted, and a new result waits until
// that register is free. Reset empties the list, clears the hash, sets the
// next power to one and restores the register defaults; stored keys are
// not cleared because only entries below the count are ever read.
// ----------------------------------------------------------------------------
module hashed_key_list_unit
#(
    parameter int DEPTH = hkl_pkg::DEPTH_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    hkl_in_if.sink        in_ch,
    hkl_out_if.source     out_ch,
    hkl_cfg_if.sink       cfg_ch
);

    localparam int W      = hkl_pkg::HASH_W;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int OCW    = hkl_pkg::COUNT_OUT_W;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_KEY,
        S_INS_HASH,
        S_INS_SUM,
        S_INS_BASE,
        S_INS_POW,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DEL_RD,
        S_DEL_CMP,
        S_SH_RD,
        S_SH_WR,
        S_RC_RD,
        S_RC_HASH,
        S_RC_POW,
        S_OUT
    } state_t;

    // Sequencer and list state.
    state_t                         state_reg, state_next;
    logic [W-1:0]                   base_reg, base_next;
    logic [W-1:0]                   mod_reg, mod_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [W-1:0]                   hash_reg, hash_next;
    logic [W-1:0]                   pow_reg, pow_next;
    logic [W-1:0]                   tmp_reg, tmp_next;
    logic [W-1:0]                   tmp2_reg, tmp2_next;
    logic [CNT_W-1:0]               idx_reg, idx_next;
    logic [hkl_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [hkl_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic                           equal_reg, equal_next;
    logic                           issued_reg, issued_next;

    // Output register.
    logic                           out_valid_reg, out_valid_next;
    logic [hkl_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                           out_equal_reg, out_equal_next;
    logic [W-1:0]                   out_hash_reg, out_hash_next;
    logic [OCW-1:0]                 out_count_reg, out_count_next;

    // Shared arithmetic unit and key memory ports.
    hkl_pkg::mm_req_t               mm_req;
    hkl_pkg::mm_rsp_t               mm_rsp;
    logic                           mm_fire;
    logic                           mem_wr_en;
    logic [ADDR_W-1:0]              mem_wr_addr;
    logic [hkl_pkg::KEY_W-1:0]      mem_wr_data;
    logic                           mem_rd_en;
    logic [ADDR_W-1:0]              mem_rd_addr;
    logic [hkl_pkg::KEY_W-1:0]      mem_rd_data;

    logic [CNT_W-1:0]               idx_plus1;
    logic [CNT_W-1:0]               idx_minus1;
    logic [CNT_W+OCW-1:0]           count_wide;
    logic                           list_full;
    logic                           mod_small;
    logic                           in_fire;

    assign idx_plus1  = idx_reg + 1'b1;
    assign idx_minus1 = idx_reg - 1'b1;
    assign count_wide = {{OCW{1'b0}}, count_next};
    assign list_full  = (count_reg == CNT_W'(DEPTH));
    assign mod_small  = (mod_reg[W-1:1] == '0);
    assign in_fire    = in_ch.valid && (state_reg == S_IDLE);

    // A pass completes when the unit answers the start that this state issued.
    assign mm_fire = issued_reg && mm_rsp.done;

    hkl_modmul u_modmul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (mod_reg),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    hkl_key_mem
    #(
        .DEPTH (DEPTH)
    )
    u_key_mem
    (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Operand selection for the shared multiply-add unit. Every pass keeps the
    // a and c operands below the modulus: raw values that may exceed it are
    // first reduced by a pass with a equal to one.
    always_comb
    begin
        mm_req.mult = '0;
        mm_req.a    = W'(1);
        mm_req.c    = '0;
        case (state_reg)
            S_INS_KEY:
            begin
                mm_req.mult = W'(key_reg);
            end
            S_INS_HASH:
            begin
                mm_req.mult = hash_reg;
            end
            S_INS_SUM:
            begin
                mm_req.mult = pow_reg;
                mm_req.a    = tmp_reg;
                mm_req.c    = tmp2_reg;
            end
            S_INS_BASE:
            begin
                mm_req.mult = base_reg;
            end
            S_INS_POW:
            begin
                mm_req.mult = pow_reg;
                mm_req.a    = tmp_reg;
            end
            S_RC_HASH:
            begin
                mm_req.mult = W'(mem_rd_data);
                mm_req.a    = pow_reg;
                mm_req.c    = hash_reg;
            end
            S_RC_POW:
            begin
                mm_req.mult = base_reg;
                mm_req.a    = pow_reg;
            end
            default:
            begin
                mm_req.mult = '0;
            end
        endcase
        mm_req.start = !issued_reg &&
                       (state_reg == S_INS_KEY || state_reg == S_INS_HASH ||
                        state_reg == S_INS_SUM || state_reg == S_INS_BASE ||
                        state_reg == S_INS_POW || state_reg == S_RC_HASH ||
                        state_reg == S_RC_POW);
    end

    // Key memory addressing. Inserts write at the current count; the gap left
    // by a delete is closed by copying each newer key one place down.
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg[ADDR_W-1:0];
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg[ADDR_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_ch.func == hkl_pkg::FUNC_INSERT && !list_full)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = count_reg[ADDR_W-1:0];
                    mem_wr_data = in_ch.key_value;
                end
            end
            S_SRCH_RD:
            begin
                mem_rd_en = (idx_reg != count_reg);
            end
            S_DEL_RD:
            begin
                mem_rd_en   = (idx_reg != '0);
                mem_rd_addr = idx_minus1[ADDR_W-1:0];
            end
            S_SH_RD:
            begin
                mem_rd_en   = (idx_plus1 < count_reg);
                mem_rd_addr = idx_plus1[ADDR_W-1:0];
            end
            S_SH_WR:
            begin
                mem_wr_en = 1'b1;
            end
            S_RC_RD:
            begin
                mem_rd_en = (idx_reg != count_reg);
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // Main sequencer.
    always_comb
    begin
        state_next      = state_reg;
        base_next       = base_reg;
        mod_next        = mod_reg;
        count_next      = count_reg;
        hash_next       = hash_reg;
        pow_next        = pow_reg;
        tmp_next        = tmp_reg;
        tmp2_next       = tmp2_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        status_next     = status_reg;
        equal_next      = equal_reg;
        issued_next     = issued_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_equal_next  = out_equal_reg;
        out_hash_next   = out_hash_reg;
        out_count_next  = out_count_reg;

        if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                hkl_pkg::REG_BASE:    base_next = cfg_ch.data;
                hkl_pkg::REG_MODULUS: mod_next  = cfg_ch.data;
                default:              base_next = base_reg;
            endcase
        end

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (mm_req.start)
        begin
            issued_next = 1'b1;
        end
        if (mm_fire)
        begin
            issued_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    key_next   = in_ch.key_value;
                    equal_next = 1'b0;
                    case (in_ch.func)
                        hkl_pkg::FUNC_INSERT:
                        begin
                            if (list_full)
                            begin
                                status_next = hkl_pkg::ST_FULL;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                state_next = S_INS_KEY;
                            end
                        end
                        hkl_pkg::FUNC_SEARCH:
                        begin
                            idx_next   = '0;
                            state_next = S_SRCH_RD;
                        end
                        hkl_pkg::FUNC_DELETE:
                        begin
                            idx_next   = count_reg;
                            state_next = S_DEL_RD;
                        end
                        default:
                        begin
                            status_next = hkl_pkg::ST_COMPARED;
                            equal_next  = (hash_reg == in_ch.other_hash);
                            state_next  = S_OUT;
                        end
                    endcase
                end
            end

            // Insert: reduce the key and the stored hash, form the new hash,
            // then reduce the base and advance the next power.
            S_INS_KEY:
            begin
                if (mm_fire)
                begin
                    tmp_next   = mm_rsp.result;
                    state_next = S_INS_HASH;
                end
            end
            S_INS_HASH:
            begin
                if (mm_fire)
                begin
                    tmp2_next  = mm_rsp.result;
                    state_next = S_INS_SUM;
                end
            end
            S_INS_SUM:
            begin
                if (mm_fire)
                begin
                    hash_next  = mm_rsp.result;
                    state_next = S_INS_BASE;
                end
            end
            S_INS_BASE:
            begin
                if (mm_fire)
                begin
                    tmp_next   = mm_rsp.result;
                    state_next = S_INS_POW;
                end
            end
            S_INS_POW:
            begin
                if (mm_fire)
                begin
                    pow_next    = mm_rsp.result;
                    count_next  = count_reg + 1'b1;
                    status_next = hkl_pkg::ST_INSERTED;
                    state_next  = S_OUT;
                end
            end

            // Search walks the list from the oldest key.
            S_SRCH_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    status_next = hkl_pkg::ST_NOT_FOUND;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP:
            begin
                if (mem_rd_data == key_reg)
                begin
                    status_next = hkl_pkg::ST_FOUND;
                    state_next  = S_OUT;
                end
                else
                begin
                    idx_next   = idx_plus1;
                    state_next = S_SRCH_RD;
                end
            end

            // Delete looks for the newest equal key first.
            S_DEL_RD:
            begin
                if (idx_reg == '0)
                begin
                    status_next = hkl_pkg::ST_NOT_FOUND;
                    state_next  = S_OUT;
                end
                else
                begin
                    idx_next   = idx_minus1;
                    state_next = S_DEL_CMP;
                end
            end
            S_DEL_CMP:
            begin
                if (mem_rd_data == key_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    state_next = S_DEL_RD;
                end
            end
            S_SH_RD:
            begin
                if (idx_plus1 < count_reg)
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    // Gap closed: drop one key and rebuild the hash from the
                    // oldest key with the current base and modulus.
                    count_next = count_reg - 1'b1;
                    idx_next   = '0;
                    hash_next  = '0;
                    pow_next   = mod_small ? '0 : W'(1);
                    state_next = S_RC_RD;
                end
            end
            S_SH_WR:
            begin
                idx_next   = idx_plus1;
                state_next = S_SH_RD;
            end
            S_RC_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    status_next = hkl_pkg::ST_DELETED;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_RC_HASH;
                end
            end
            S_RC_HASH:
            begin
                if (mm_fire)
                begin
                    hash_next  = mm_rsp.result;
                    state_next = S_RC_POW;
                end
            end
            S_RC_POW:
            begin
                if (mm_fire)
                begin
                    pow_next   = mm_rsp.result;
                    idx_next   = idx_plus1;
                    state_next = S_RC_RD;
                end
            end

            // Hand the result over once the output register is free.
            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_equal_next  = equal_reg;
                    out_hash_next   = hash_reg;
                    out_count_next  = count_wide[OCW-1:0];
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_reg       <= hkl_pkg::BASE_RESET;
            mod_reg        <= hkl_pkg::MODULUS_RESET;
            count_reg      <= '0;
            hash_reg       <= '0;
            pow_reg        <= W'(1);
            tmp_reg        <= '0;
            tmp2_reg       <= '0;
            idx_reg        <= '0;
            key_reg        <= '0;
            status_reg     <= hkl_pkg::ST_INSERTED;
            equal_reg      <= 1'b0;
            issued_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= hkl_pkg::ST_INSERTED;
            out_equal_reg  <= 1'b0;
            out_hash_reg   <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            base_reg       <= base_next;
            mod_reg        <= mod_next;
            count_reg      <= count_next;
            hash_reg       <= hash_next;
            pow_reg        <= pow_next;
            tmp_reg        <= tmp_next;
            tmp2_reg       <= tmp2_next;
            idx_reg        <= idx_next;
            key_reg        <= key_next;
            status_reg     <= status_next;
            equal_reg      <= equal_next;
            issued_reg     <= issued_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_equal_reg  <= out_equal_next;
            out_hash_reg   <= out_hash_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign cfg_ch.ready        = 1'b1;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.hashes_equal = out_equal_reg;
    assign out_ch.hash_now     = out_hash_reg;
    assign out_ch.key_count    = out_count_reg;

endmodule

>>> bench/hkl_result_checker.sv
// ----------------------------------------------------------------------------
// hkl_result_checker: result checking for the hashed key list unit
// Watches the request, result and register write channels and keeps its own
// copy of the key list, the hash and the registers. It works out the
// expected result of every accepted request and compares each accepted
// result field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module hkl_result_checker
    import hkl_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    hkl_in_if    in_ch,
    hkl_out_if   out_ch,
    hkl_cfg_if   cfg_ch,
    output int   mismatch_count,
    output int   awaited_count
);

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   hashes_equal;
        logic [HASH_W-1:0]      hash_now;
        logic [COUNT_OUT_W-1:0] key_count;
    } list_outcome_t;

    logic [KEY_W-1:0] key_copy [DEPTH];
    int unsigned      held;
    longint unsigned  hash_acc;
    longint unsigned  power_acc;
    longint unsigned  base_reg;
    longint unsigned  modulus_reg;
    list_outcome_t    outcomes_due [$];

    // A modulus of 0 or 1 behaves as modulus 1, so everything reduces to 0.
    function automatic longint unsigned mod_reduce(longint unsigned x);
        if (modulus_reg < 2)
            return 0;
        return x % modulus_reg;
    endfunction

    task automatic rehash_list();
        longint unsigned h;
        longint unsigned pw;
        h  = 0;
        pw = mod_reduce(1);
        for (int j = 0; j < int'(held); j++)
        begin
            h  = mod_reduce(h + mod_reduce(64'(key_copy[j]) * pw));
            pw = mod_reduce(pw * base_reg);
        end
        hash_acc  = h;
        power_acc = pw;
    endtask

    task automatic apply_list_op(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key,
                                 input logic [HASH_W-1:0] other, output list_outcome_t res);
        int pos;
        res = '0;
        pos = -1;
        case (op)
            FUNC_INSERT:
            begin
                if (held >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    key_copy[held] = key;
                    hash_acc  = mod_reduce(hash_acc + mod_reduce(64'(key) * power_acc));
                    power_acc = mod_reduce(power_acc * base_reg);
                    held++;
                    res.status = ST_INSERTED;
                end
            end
            FUNC_SEARCH:
            begin
                res.status = ST_NOT_FOUND;
                for (int j = 0; j < int'(held); j++)
                    if (key_copy[j] == key)
                        res.status = ST_FOUND;
            end
            FUNC_DELETE:
            begin
                // The newest equal key goes; newer keys slide down over it.
                for (int j = int'(held) - 1; j >= 0 && pos < 0; j--)
                    if (key_copy[j] == key)
                        pos = j;
                if (pos < 0)
                    res.status = ST_NOT_FOUND;
                else
                begin
                    for (int j = pos; j + 1 < int'(held); j++)
                        key_copy[j] = key_copy[j + 1];
                    held--;
                    rehash_list();
                    res.status = ST_DELETED;
                end
            end
            FUNC_COMPARE:
            begin
                res.status       = ST_COMPARED;
                res.hashes_equal = (hash_acc == 64'(other));
            end
        endcase
        res.hash_now  = HASH_W'(hash_acc);
        res.key_count = COUNT_OUT_W'(held);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        list_outcome_t seen;
        list_outcome_t due;
        if (!rst_n)
        begin
            base_reg       = BASE_RESET;
            modulus_reg    = MODULUS_RESET;
            held           = 0;
            hash_acc       = 0;
            power_acc      = 1;
            mismatch_count = 0;
            outcomes_due.delete();
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    REG_BASE:    base_reg    = cfg_ch.data;
                    REG_MODULUS: modulus_reg = cfg_ch.data;
                    default:     ;
                endcase
            end
            if (out_ch.valid && out_ch.ready)
            begin
                seen.status       = out_ch.status;
                seen.hashes_equal = out_ch.hashes_equal;
                seen.hash_now     = out_ch.hash_now;
                seen.key_count    = out_ch.key_count;
                if (outcomes_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with none due, expected nothing, actual %p",
                             $time, seen);
                end
                else
                begin
                    due = outcomes_due.pop_front();
                    check_field("status", due.status, seen.status);
                    check_field("hashes_equal", due.hashes_equal, seen.hashes_equal);
                    check_field("hash_now", due.hash_now, seen.hash_now);
                    check_field("key_count", due.key_count, seen.key_count);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                apply_list_op(in_ch.func, in_ch.key_value, in_ch.other_hash, due);
                outcomes_due.push_back(due);
            end
        end
        awaited_count = outcomes_due.size();
    end

endmodule

>>> bench/tb_hashed_key_list_unit.sv
// ----------------------------------------------------------------------------
// tb_hashed_key_list_unit: testbench of the hashed key list unit
// Drives list operations and register writes into the unit, with random gaps
// on the request side and random stalls on the result side, and lets a
// checker beside the unit compare every result with its own expectation.
// ----------------------------------------------------------------------------
module tb_hashed_key_list_unit;
    import hkl_pkg::*;

    localparam int     DEPTH           = DEPTH_DEFAULT;
    localparam int     HALF_PERIOD     = 2;
    localparam int     RESET_CYCLES    = 9;
    localparam int     POOL_SIZE       = 16;
    localparam int     RANDOM_PHASES   = 9;
    localparam int     ITEMS_PER_PHASE = 190;
    // Long enough for the unit to fill its output register and stall its input.
    localparam int     HOLD_CYCLES     = 400;
    // The slowest operation is a delete on a full list; after the last result
    // we wait at least that long for stray results.
    localparam int     TAIL_CYCLES     = 60 * DEPTH;
    // Slowest correct run: about 1900 requests, each a full-list delete plus
    // the longest gaps and stalls, taken several times over.
    localparam longint WATCHDOG_CYCLES = 40_000_000;

    logic clk = 1'b0;
    logic rst_n;

    hkl_in_if  in_ch ();
    hkl_out_if out_ch ();
    hkl_cfg_if cfg_ch ();

    // Bookkeeping of the stimulus side. The last result tells the request
    // generator roughly how full the list is and which hash it holds.
    int                     requests_sent      = 0;
    int                     results_seen       = 0;
    int                     sender_idle_pct    = 0;
    int                     receiver_stall_pct = 0;
    int                     hold_requests      = 0;
    int                     holds_served       = 0;
    logic [HASH_W-1:0]      last_hash          = '0;
    logic [COUNT_OUT_W-1:0] last_count         = '0;
    logic [KEY_W-1:0]       key_pool [POOL_SIZE];
    int                     mismatch_count;
    int                     awaited_count;

    hashed_key_list_unit #(
        .DEPTH (DEPTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    hkl_result_checker #(
        .DEPTH (DEPTH)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_ch         (cfg_ch),
        .mismatch_count (mismatch_count),
        .awaited_count  (awaited_count)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            results_seen <= results_seen + 1;
            last_hash    <= out_ch.hash_now;
            last_count   <= out_ch.key_count;
        end
    end

    // Result side. Normally ready is rolled every cycle against the stall
    // rate of the phase. When a hold-off is asked for, ready stays low for a
    // counted stretch while the request side keeps offering, so the unit's
    // output register fills and its input stops taking requests.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_served++;
            end
            else
                out_ch.ready = ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin
        #(WATCHDOG_CYCLES * 2 * HALF_PERIOD);
        $display("Mismatches found");
        $finish;
    end

    // Offers one request, with random idle cycles in front of it, and returns
    // at the rising edge where it is taken. Whatever comes next drives valid
    // again at the following falling edge.
    task automatic send_request(input logic [FUNC_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic [HASH_W-1:0] other);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.func       = op;
        in_ch.key_value  = key;
        in_ch.other_hash = other;
        do @(posedge clk); while (!in_ch.ready);
        requests_sent++;
    endtask

    // Drops valid and waits until every request sent has its result back.
    // The unit works on one request at a time, so it is idle from then on.
    task automatic wait_until_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (results_seen != requests_sent)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [HASH_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // A compare request that is meant to hit: once the unit is idle the last
    // result carries the hash that the list holds now.
    task automatic compare_current();
        wait_until_idle();
        send_request(FUNC_COMPARE, KEY_W'($urandom), last_hash);
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
            default: begin sender_idle_pct = 9;  receiver_stall_pct = 9;  end
        endcase
    endtask

    function automatic logic [KEY_W-1:0] pool_key();
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // One random request. Inserts always take a key from the pool, so that
    // deletes can take every stored key out again. The mix leans toward
    // deletes when the list grows, which keeps it short: a delete costs time
    // in proportion to the number of keys held.
    task automatic send_random_request();
        int               roll;
        int               insert_pct;
        int               delete_pct;
        logic [KEY_W-1:0] key;
        logic [HASH_W-1:0] other;
        roll = $urandom_range(0, 99);
        if (last_count < 4)
        begin
            insert_pct = 55;
            delete_pct = 15;
        end
        else if (last_count > 14)
        begin
            insert_pct = 15;
            delete_pct = 45;
        end
        else
        begin
            insert_pct = 35;
            delete_pct = 20;
        end
        // Most search and delete keys come from the pool and often hit; the rest
        // are random and almost always miss.
        key   = ($urandom_range(0, 99) < 80) ? pool_key() : KEY_W'($urandom);
        // Half the compares use the last hash seen, which is often current.
        other = ($urandom_range(0, 1) == 1) ? last_hash : HASH_W'($urandom);
        if (roll < insert_pct)
            send_request(FUNC_INSERT, pool_key(), other);
        else if (roll < insert_pct + delete_pct)
            send_request(FUNC_DELETE, key, other);
        else if (roll < insert_pct + delete_pct + 20)
            send_request(FUNC_COMPARE, key, other);
        else
            send_request(FUNC_SEARCH, key, other);
    endtask

    initial
    begin
        logic [HASH_W-1:0] base_val;
        logic [HASH_W-1:0] mod_val;
        logic [KEY_W-1:0]  absent_key;
        bit                clash;

        in_ch.valid      = 1'b0;
        in_ch.func       = FUNC_INSERT;
        in_ch.key_value  = '0;
        in_ch.other_hash = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_BASE;
        cfg_ch.data      = '0;
        rst_n            = 1'b0;

        // The pool holds both key extremes and random keys. A key that is
        // surely absent is picked for the misses on a full list.
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < POOL_SIZE; k++)
            key_pool[k] = KEY_W'($urandom);
        do
        begin
            absent_key = KEY_W'($urandom);
            clash = 1'b0;
            foreach (key_pool[k])
                if (key_pool[k] == absent_key)
                    clash = 1'b1;
        end
        while (clash);

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Directed requests at the register reset values. The empty list has
        // hash zero, so the first compare hits and the second misses. The
        // list is then built as 0, FFFF, FFFF, 0 and taken apart again:
        // a delete in the middle, a delete of the newest key (the head, whose
        // removal must recompute the hash rather than clear it), a delete of
        // an absent key, and deletes down to the empty list.
        set_idle_mode(0);
        send_request(FUNC_COMPARE, '0, '0);
        send_request(FUNC_COMPARE, '1, '1);
        send_request(FUNC_SEARCH, '0, '0);
        send_request(FUNC_DELETE, '0, '0);
        send_request(FUNC_INSERT, '0, '0);
        send_request(FUNC_INSERT, '1, '0);
        send_request(FUNC_INSERT, '1, '0);
        send_request(FUNC_INSERT, '0, '0);
        send_request(FUNC_SEARCH, '1, '0);
        send_request(FUNC_SEARCH, 16'h5555, '0);
        compare_current();
        send_request(FUNC_DELETE, '1, '0);
        send_request(FUNC_DELETE, '0, '0);
        send_request(FUNC_DELETE, 16'h7777, '0);
        send_request(FUNC_COMPARE, '0, HASH_W'($urandom));
        send_request(FUNC_DELETE, '0, '0);
        send_request(FUNC_DELETE, '1, '0);
        send_request(FUNC_COMPARE, '0, '0);

        // Full list. The list is empty here; it is filled to DEPTH keys,
        // further inserts must report full, one key is taken out and put
        // back, and then every stored key is deleted, which empties it.
        set_idle_mode(3);
        for (int i = 0; i < DEPTH; i++)
            send_request(FUNC_INSERT, key_pool[i % POOL_SIZE], '0);
        repeat (4) send_request(FUNC_INSERT, pool_key(), '0);
        send_request(FUNC_SEARCH, key_pool[3], '0);
        send_request(FUNC_SEARCH, absent_key, '0);
        compare_current();
        send_request(FUNC_DELETE, key_pool[5], '0);
        send_request(FUNC_DELETE, absent_key, '0);
        send_request(FUNC_INSERT, key_pool[5], '0);
        send_request(FUNC_INSERT, key_pool[0], '0);
        compare_current();
        for (int i = 0; i < DEPTH; i++)
            send_request(FUNC_DELETE, key_pool[i % POOL_SIZE], '0);

        // Random phases. Each one first lets the unit go idle, then writes
        // both registers and runs random requests under one idling mode. The
        // list is kept across phases, so a register change lands on a list
        // whose hash was built with the old values.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       begin base_val = BASE_RESET; mod_val = MODULUS_RESET; end
                1:       begin base_val = 23'd2;       mod_val = 23'd8388607;   end
                2:       begin base_val = 23'd8388607; mod_val = 23'd2;         end
                3:       begin base_val = 23'd8388607; mod_val = 23'd8388607;   end
                4:       begin base_val = 23'd2;       mod_val = 23'd2;         end
                5:
                begin
                    base_val = HASH_W'($urandom_range(2, 8388607));
                    mod_val  = HASH_W'($urandom_range(2, 8388607));
                end
                // Modulus zero and one both make every reduced value zero.
                6:       begin base_val = 23'd1;       mod_val = 23'd0;         end
                7:       begin base_val = 23'd0;       mod_val = 23'd1;         end
                // A base above the modulus is written as it is.
                default: begin base_val = 23'd5000000; mod_val = 23'd4093;      end
            endcase
            wait_until_idle();
            write_register(REG_BASE, base_val);
            write_register(REG_MODULUS, mod_val);
            set_idle_mode(phase % 4);
            if (phase == 0)
                hold_requests++;
            repeat (ITEMS_PER_PHASE) send_random_request();
        end

        wait_until_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/hkl_pkg.sv
rtl/core/hkl_in_if.sv
rtl/core/hkl_out_if.sv
rtl/core/hkl_cfg_if.sv
rtl/core/hkl_modmul.sv
rtl/core/hkl_key_mem.sv
rtl/core/hashed_key_list_unit.sv
bench/hkl_result_checker.sv
bench/tb_hashed_key_list_unit.sv
